/* src/ntat_pkg.sv */
// ============================================================================
// ntat_pkg
// Shared constants, codes and record types of the nearest-track association
// block with track expiry.
// ============================================================================
package ntat_pkg;

    // Table size and coordinate width
    localparam int MAX_TRACKS  = 32;
    localparam int COORD_BITS  = 24;
    localparam int SLOT_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int COUNT_W     = $clog2(MAX_TRACKS + 1);

    // Scan sequencing: one slot read per cycle, then the distance pipe drains
    localparam int FRAME_DONE  = MAX_TRACKS;
    localparam int CENT_DONE   = MAX_TRACKS + 3;
    localparam int SCAN_CNT_W  = $clog2(CENT_DONE + 1);

    // Datapath widths
    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int RADIUS_W    = 16;
    localparam int HOLD_W      = 20;
    localparam int RSQ_W       = 2 * RADIUS_W;
    localparam int DIST_W      = RSQ_W + 1;
    localparam int DIFF_W      = COORD_BITS + 1;

    // Stream field widths and positions
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int COORD_IN_W  = 24;
    localparam int SLOT_OUT_W  = 5;
    localparam int COUNT_OUT_W = 6;
    localparam int IN_CMD_LSB  = 0;
    localparam int IN_NOW_LSB  = IN_CMD_LSB + CMD_W;
    localparam int IN_CX_LSB   = IN_NOW_LSB + TIME_W;
    localparam int IN_CY_LSB   = IN_CX_LSB + COORD_IN_W;
    localparam int IN_BITS     = IN_CY_LSB + COORD_IN_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_STAT_LSB  = 0;
    localparam int OUT_ID_LSB    = OUT_STAT_LSB + STATUS_W;
    localparam int OUT_SLOT_LSB  = OUT_ID_LSB + ID_W;
    localparam int OUT_COUNT_LSB = OUT_SLOT_LSB + SLOT_OUT_W;
    localparam int OUT_BITS      = OUT_COUNT_LSB + COUNT_OUT_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_BITS;
    localparam int IN_PAD_W      = IN_TDATA_W - IN_BITS;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = HOLD_W;
    localparam int ASSOC_RESET = 800;
    localparam int HOLD_RESET  = 5000;
    localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(ASSOC_RESET * ASSOC_RESET);

    // Input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_FRAME    = 2'd0,
        CMD_CENTROID = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_e_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_FRAME   = 3'd0,
        ST_UPDATED = 3'd1,
        ST_CREATED = 3'd2,
        ST_FULL    = 3'd3,
        ST_CLEARED = 3'd4
    } status_e_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ASSOC_DIST = 1'd0,
        CFG_HOLD       = 1'd1
    } cfg_e_t;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_FRAME_SCAN,
        SEQ_CENT_SCAN,
        SEQ_FINISH
    } seq_e_t;

    // One track record as held in the track memory
    typedef struct packed {
        logic [ID_W-1:0]              id;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic [TIME_W-1:0]            expiry;
    } track_rec_t;

    // Memory write request
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        track_rec_t        data;
    } mem_wr_t;

    // Slot read in flight, aligned with the memory read data
    typedef struct packed {
        logic              frame;
        logic              cent;
        logic              elig;
        logic [SLOT_W-1:0] slot;
    } scan_req_t;

    // Candidate from the distance pipeline
    typedef struct packed {
        logic              qual;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dsq;
    } dist_res_t;

endpackage

/* src/ntat_track_mem.sv */
// ============================================================================
// ntat_track_mem
// Track record memory: one write port, one read port, registered read data.
// ============================================================================
module ntat_track_mem import ntat_pkg::*; (
    input  logic              aclk,
    input  mem_wr_t           mem_wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output track_rec_t        rd_data
);

    track_rec_t mem_array [MAX_TRACKS];
    track_rec_t rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            mem_array[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/ntat_dist.sv */
// ============================================================================
// ntat_dist
// Three-stage distance pipeline: absolute differences and box check,
// squares, then sum and radius check for one track record per cycle.
// ============================================================================
module ntat_dist import ntat_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  scan_req_t                    scan_req,
    input  track_rec_t                   rec,
    input  logic signed [COORD_BITS-1:0] cent_x,
    input  logic signed [COORD_BITS-1:0] cent_y,
    input  logic [RADIUS_W-1:0]          radius,
    input  logic [RSQ_W-1:0]             radius_sq,
    output dist_res_t                    dist_res
);

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        adx;
    logic [DIFF_W-1:0]        ady;
    logic [DIST_W-1:0]        sum;

    logic                a_tag_reg, b_tag_reg;
    logic                a_ok_reg, b_ok_reg;
    logic [RADIUS_W-1:0] a_ax_reg, a_ay_reg;
    logic [RSQ_W-1:0]    b_sqx_reg, b_sqy_reg;
    logic [SLOT_W-1:0]   a_slot_reg, b_slot_reg;
    logic [ID_W-1:0]     a_id_reg, b_id_reg;
    dist_res_t           res_reg;

    // Stage A inputs: differences and their magnitudes
    always_comb begin
        dx  = {cent_x[COORD_BITS-1], cent_x} - {rec.cx[COORD_BITS-1], rec.cx};
        dy  = {cent_y[COORD_BITS-1], cent_y} - {rec.cy[COORD_BITS-1], rec.cy};
        adx = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
        ady = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
    end

    // Stage C inputs: squared distance
    assign sum = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};

    // Valid tags of the pipeline and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_tag_reg <= 1'b0;
            b_tag_reg <= 1'b0;
            res_reg   <= '0;
        end else begin
            a_tag_reg    <= scan_req.cent;
            b_tag_reg    <= a_tag_reg;
            res_reg.qual <= b_tag_reg && b_ok_reg && (sum <= {1'b0, radius_sq});
            res_reg.slot <= b_slot_reg;
            res_reg.id   <= b_id_reg;
            res_reg.dsq  <= sum;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        // A track outside the square box around the centroid never qualifies.
        a_ok_reg     <= scan_req.elig && (adx <= DIFF_W'(radius)) &&
                        (ady <= DIFF_W'(radius));
        a_ax_reg     <= RADIUS_W'(adx);
        a_ay_reg     <= RADIUS_W'(ady);
        a_slot_reg   <= scan_req.slot;
        a_id_reg     <= rec.id;
        b_ok_reg     <= a_ok_reg;
        b_sqx_reg    <= {{RADIUS_W{1'b0}}, a_ax_reg} * {{RADIUS_W{1'b0}}, a_ax_reg};
        b_sqy_reg    <= {{RADIUS_W{1'b0}}, a_ay_reg} * {{RADIUS_W{1'b0}}, a_ay_reg};
        b_slot_reg   <= a_slot_reg;
        b_id_reg     <= a_id_reg;
    end

    assign dist_res = res_reg;

endmodule

/* src/ntat_ctrl.sv */
// ============================================================================
// ntat_ctrl
// Sequencer of the track table: valid and matched bits, track count, slot
// scans, nearest-track selection, table update and the result register.
// ============================================================================
module ntat_ctrl import ntat_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [CMD_W-1:0]             in_cmd,
    input  logic [TIME_W-1:0]            in_now,
    input  logic signed [COORD_BITS-1:0] in_cx,
    input  logic signed [COORD_BITS-1:0] in_cy,
    // Result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [STATUS_W-1:0]          out_status,
    output logic [ID_W-1:0]              out_id,
    output logic [SLOT_W-1:0]            out_slot,
    output logic [COUNT_W-1:0]           out_count,
    // Configuration writes
    input  logic                         cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // Track memory
    output logic [SLOT_W-1:0]            mem_rd_addr,
    output mem_wr_t                      mem_wr,
    input  track_rec_t                   mem_rd_data,
    // Distance pipeline
    output scan_req_t                    scan_req,
    output logic signed [COORD_BITS-1:0] cent_x,
    output logic signed [COORD_BITS-1:0] cent_y,
    output logic [RADIUS_W-1:0]          radius,
    output logic [RSQ_W-1:0]             radius_sq,
    input  dist_res_t                    dist_res
);

    seq_e_t state_reg, state_next;

    logic [SCAN_CNT_W-1:0]        cnt_reg;
    logic [CMD_W-1:0]             op_reg;
    logic [TIME_W-1:0]            now_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [TIME_W-1:0]            frame_exp_reg, frame_exp_next;
    logic [ID_W-1:0]              next_id_reg, next_id_next;
    logic [MAX_TRACKS-1:0]        valid_reg, valid_next;
    logic [MAX_TRACKS-1:0]        matched_reg, matched_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic [SLOT_W-1:0]            free_slot_reg, free_slot;
    logic                         full_reg;
    logic                         best_found_reg;
    logic [SLOT_W-1:0]            best_slot_reg;
    logic [ID_W-1:0]              best_id_reg;
    logic [DIST_W-1:0]            best_d_reg;
    logic [RADIUS_W-1:0]          assoc_reg;
    logic [HOLD_W-1:0]            hold_reg;
    logic [RSQ_W-1:0]             rsq_reg;
    logic [RSQ_W-1:0]             cfg_sq;
    scan_req_t                    scan_req_reg, scan_req_next;
    logic                         m_valid_reg;
    logic [STATUS_W-1:0]          out_status_reg, out_status_next;
    logic [ID_W-1:0]              out_id_reg, out_id_next;
    logic [SLOT_W-1:0]            out_slot_reg, out_slot_next;
    logic [COUNT_W-1:0]           out_count_reg;

    logic                  accept;
    logic                  out_free;
    logic                  issue_en;
    logic                  finish_fire;
    logic                  scan_active;
    logic                  drop;
    logic                  take_best;
    logic [SLOT_W-1:0]     scan_slot;
    logic [TIME_W:0]       exp_sum;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_slot = cnt_reg[SLOT_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        CMD_FRAME:    state_next = SEQ_FRAME_SCAN;
                        CMD_CENTROID: state_next = SEQ_CENT_SCAN;
                        CMD_CLEAR:    state_next = SEQ_FINISH;
                        default:      state_next = SEQ_IDLE;
                    endcase
                end
            end
            SEQ_FRAME_SCAN: begin
                if (cnt_reg == SCAN_CNT_W'(FRAME_DONE)) begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_CENT_SCAN: begin
                if (cnt_reg == SCAN_CNT_W'(CENT_DONE)) begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH: begin
                if (out_free) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready     = 1'b0;
        scan_active = 1'b0;
        finish_fire = 1'b0;
        case (state_reg)
            SEQ_IDLE:       s_ready = 1'b1;
            SEQ_FRAME_SCAN: scan_active = 1'b1;
            SEQ_CENT_SCAN:  scan_active = 1'b1;
            SEQ_FINISH:     finish_fire = out_free;
            default:        s_ready = 1'b0;
        endcase
        issue_en = scan_active && (cnt_reg < SCAN_CNT_W'(MAX_TRACKS));
    end

    // Lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // Slot read issue; eligibility is taken from the bit vectors at issue time.
    always_comb begin
        scan_req_next.frame = issue_en && (state_reg == SEQ_FRAME_SCAN);
        scan_req_next.cent  = issue_en && (state_reg == SEQ_CENT_SCAN);
        scan_req_next.slot  = scan_slot;
        if (state_reg == SEQ_FRAME_SCAN) begin
            scan_req_next.elig = valid_reg[scan_slot];
        end else begin
            scan_req_next.elig = valid_reg[scan_slot] && !matched_reg[scan_slot];
        end
    end

    // Expiry check of a frame scan, one slot per cycle
    assign drop = scan_req_reg.frame && scan_req_reg.elig && (mem_rd_data.expiry <= now_reg);

    // Nearest candidate; ties on distance go to the lower id.
    assign take_best = (state_reg == SEQ_CENT_SCAN) && dist_res.qual &&
                       (!best_found_reg || (dist_res.dsq < best_d_reg) ||
                        ((dist_res.dsq == best_d_reg) && (dist_res.id < best_id_reg)));

    // Saturated frame expiry
    assign exp_sum = {1'b0, in_now} + (TIME_W + 1)'(hold_reg);
    always_comb begin
        frame_exp_next = frame_exp_reg;
        if (accept && (in_cmd == CMD_FRAME)) begin
            frame_exp_next = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];
        end
    end

    // Table bits, count and id counter
    always_comb begin
        valid_next      = valid_reg;
        matched_next    = matched_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        out_status_next = ST_FRAME;
        out_id_next     = '0;
        out_slot_next   = '0;
        if (accept && (in_cmd == CMD_FRAME)) begin
            matched_next = '0;
        end
        if (drop) begin
            valid_next[scan_req_reg.slot] = 1'b0;
            count_next                    = count_reg - COUNT_W'(1);
        end
        if (finish_fire) begin
            case (op_reg)
                CMD_CENTROID: begin
                    if (best_found_reg) begin
                        matched_next[best_slot_reg] = 1'b1;
                        out_status_next             = ST_UPDATED;
                        out_id_next                 = best_id_reg;
                        out_slot_next               = best_slot_reg;
                    end else if (full_reg) begin
                        out_status_next = ST_FULL;
                    end else begin
                        valid_next[free_slot_reg]   = 1'b1;
                        matched_next[free_slot_reg] = 1'b1;
                        count_next                  = count_reg + COUNT_W'(1);
                        next_id_next                = next_id_reg + ID_W'(1);
                        out_status_next             = ST_CREATED;
                        out_id_next                 = next_id_reg;
                        out_slot_next               = free_slot_reg;
                    end
                end
                CMD_CLEAR: begin
                    valid_next      = '0;
                    matched_next    = '0;
                    count_next      = '0;
                    next_id_next    = ID_W'(1);
                    out_status_next = ST_CLEARED;
                end
                default: out_status_next = ST_FRAME;
            endcase
        end
    end

    // Memory write for an updated or a created track
    always_comb begin
        mem_wr.en          = finish_fire && (op_reg == CMD_CENTROID) &&
                             (best_found_reg || !full_reg);
        mem_wr.addr        = best_found_reg ? best_slot_reg : free_slot_reg;
        mem_wr.data.id     = best_found_reg ? best_id_reg : next_id_reg;
        mem_wr.data.cx     = cx_reg;
        mem_wr.data.cy     = cy_reg;
        mem_wr.data.expiry = frame_exp_reg;
    end

    assign cfg_sq = {{RADIUS_W{1'b0}}, cfg_data[RADIUS_W-1:0]} *
                    {{RADIUS_W{1'b0}}, cfg_data[RADIUS_W-1:0]};

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= SEQ_IDLE;
            cnt_reg            <= '0;
            valid_reg          <= '0;
            matched_reg        <= '0;
            count_reg          <= '0;
            next_id_reg        <= ID_W'(1);
            frame_exp_reg      <= '0;
            best_found_reg     <= 1'b0;
            scan_req_reg       <= '0;
            m_valid_reg        <= 1'b0;
            assoc_reg          <= RADIUS_W'(ASSOC_RESET);
            hold_reg           <= HOLD_W'(HOLD_RESET);
            rsq_reg            <= RSQ_RESET;
        end else begin
            state_reg          <= state_next;
            cnt_reg            <= scan_active ? (cnt_reg + SCAN_CNT_W'(1)) : '0;
            valid_reg          <= valid_next;
            matched_reg        <= matched_next;
            count_reg          <= count_next;
            next_id_reg        <= next_id_next;
            frame_exp_reg      <= frame_exp_next;
            scan_req_reg       <= scan_req_next;
            if (accept) begin
                best_found_reg <= 1'b0;
            end else if (take_best) begin
                best_found_reg <= 1'b1;
            end
            if (finish_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ASSOC_DIST: begin
                        assoc_reg <= cfg_data[RADIUS_W-1:0];
                        rsq_reg   <= cfg_sq;
                    end
                    CFG_HOLD: hold_reg <= cfg_data[HOLD_W-1:0];
                    default:  hold_reg <= hold_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg        <= in_cmd;
            now_reg       <= in_now;
            cx_reg        <= in_cx;
            cy_reg        <= in_cy;
            free_slot_reg <= free_slot;
            full_reg      <= &valid_reg;
        end
        if (take_best) begin
            best_slot_reg <= dist_res.slot;
            best_id_reg   <= dist_res.id;
            best_d_reg    <= dist_res.dsq;
        end
        if (finish_fire) begin
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_slot_reg   <= out_slot_next;
            out_count_reg  <= count_next;
        end
    end

    assign mem_rd_addr = scan_slot;
    assign scan_req    = scan_req_reg;
    assign cent_x      = cx_reg;
    assign cent_y      = cy_reg;
    assign radius      = assoc_reg;
    assign radius_sq   = rsq_reg;
    assign m_valid     = m_valid_reg;
    assign out_status  = out_status_reg;
    assign out_id      = out_id_reg;
    assign out_slot    = out_slot_reg;
    assign out_count   = out_count_reg;

endmodule

/* src/nearest_track_association_ttl_top.sv */
// ============================================================================
// nearest_track_association_ttl_top
// Obstacle track table with nearest-neighbor association and track expiry.
// ============================================================================
//
//  Channel   Ports                               Direction  Content
//  -------   ---------------------------------   ---------  ----------------------------
//  input     s_tvalid s_tready s_tdata[87:0]     in         cmd, now_ms, x and y position
//  result    m_tvalid m_tready m_tdata[47:0]     out        status, track_id, slot, count
//  config    cfg_wr_en cfg_index cfg_data[19:0]  in         assoc_dist_mm, hold_ms
//
//  A frame start and a centroid read the track memory one slot per cycle
//  through its single read port, and a centroid also waits for the
//  three-stage distance pipe to drain. Clear goes straight to the finish
//  state; an unused command is taken and dropped.
//  Reset is synchronous and clears the slot valid bits at once; there is no
//  memory clearing pass. A result waits in the output register while the next
//  item is taken; an item is finished only once that register is free.
//
module nearest_track_association_ttl_top import ntat_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // cmd[1:0], now_ms[33:2], pos_x[57:34], pos_y[81:58], zero fill
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // status[2:0], track_id[34:3], slot[39:35], live_count[45:40], zero fill
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CMD_W-1:0]             in_cmd;
    logic [TIME_W-1:0]            in_now;
    logic signed [COORD_BITS-1:0] in_cx;
    logic signed [COORD_BITS-1:0] in_cy;
    logic [STATUS_W-1:0]          out_status;
    logic [ID_W-1:0]              out_id;
    logic [SLOT_W-1:0]            out_slot;
    logic [COUNT_W-1:0]           out_count;
    logic [SLOT_W-1:0]            mem_rd_addr;
    mem_wr_t                      mem_wr;
    track_rec_t                   mem_rd_data;
    scan_req_t                    scan_req;
    logic signed [COORD_BITS-1:0] cent_x;
    logic signed [COORD_BITS-1:0] cent_y;
    logic [RADIUS_W-1:0]          radius;
    logic [RSQ_W-1:0]             radius_sq;
    dist_res_t                    dist_res;

    // Unpack the input transfer
    assign in_cmd = s_tdata[IN_CMD_LSB +: CMD_W];
    assign in_now = s_tdata[IN_NOW_LSB +: TIME_W];
    assign in_cx  = COORD_BITS'($signed(s_tdata[IN_CX_LSB +: COORD_IN_W]));
    assign in_cy  = COORD_BITS'($signed(s_tdata[IN_CY_LSB +: COORD_IN_W]));

    ntat_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .in_cmd      (in_cmd),
        .in_now      (in_now),
        .in_cx       (in_cx),
        .in_cy       (in_cy),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .out_status  (out_status),
        .out_id      (out_id),
        .out_slot    (out_slot),
        .out_count   (out_count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr      (mem_wr),
        .mem_rd_data (mem_rd_data),
        .scan_req    (scan_req),
        .cent_x      (cent_x),
        .cent_y      (cent_y),
        .radius      (radius),
        .radius_sq   (radius_sq),
        .dist_res    (dist_res)
    );

    ntat_track_mem u_mem (
        .aclk    (aclk),
        .mem_wr  (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ntat_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_req  (scan_req),
        .rec       (mem_rd_data),
        .cent_x    (cent_x),
        .cent_y    (cent_y),
        .radius    (radius),
        .radius_sq (radius_sq),
        .dist_res  (dist_res)
    );

    // Pack the result transfer
    assign m_tdata = {{OUT_PAD_W{1'b0}}, COUNT_OUT_W'(out_count), SLOT_OUT_W'(out_slot),
                      out_id, out_status};

endmodule

/* src/ntat_checker.sv */
// ============================================================================
// ntat_checker
// Port-level checks of the track table block, bound to its top level.
// ============================================================================
module ntat_checker import ntat_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0]    st;
    logic [ID_W-1:0]        tid;
    logic [SLOT_OUT_W-1:0]  slt;
    logic [COUNT_OUT_W-1:0] cnt;

    assign st  = m_tdata[OUT_STAT_LSB +: STATUS_W];
    assign tid = m_tdata[OUT_ID_LSB +: ID_W];
    assign slt = m_tdata[OUT_SLOT_LSB +: SLOT_OUT_W];
    assign cnt = m_tdata[OUT_COUNT_LSB +: COUNT_OUT_W];

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result transfer holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Status codes and track count stay within the table's range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st <= ST_CLEARED) && (cnt <= COUNT_OUT_W'(MAX_TRACKS)))
        else $error("status or track count out of range");

    // A clear leaves an empty table and no id or slot.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_CLEARED) |-> (tid == '0) && (slt == '0) && (cnt == '0))
        else $error("clear result not empty");

    // A full-table result means every slot holds a track.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == ST_FULL) |->
            (cnt == COUNT_OUT_W'(MAX_TRACKS)) && (tid == '0) && (slt == '0))
        else $error("table full reported with free slots");

endmodule

bind nearest_track_association_ttl_top ntat_checker u_ntat_checker (.*);
